// ----- rtl/stet_pkg.sv -----
package stet_pkg;

  localparam int unsigned DefDepth   = 32;
  localparam int unsigned DefTagBits = 16;

  localparam logic [4:0] MaxHour   = 5'd23;
  localparam logic [5:0] MaxMinute = 6'd59;

  // Width of the sort key: hour above minute.
  localparam int unsigned KeyW = 11;

  typedef enum logic [1:0] {
    MODE_INSERT,
    MODE_DELETE,
    MODE_READ,
    MODE_IGNORE
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_RANGE,
    ST_BAD_TIME
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_WR,
    S_DEL_MV,
    S_RD_OUT
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [4:0]  event_hour;
    logic [5:0]  event_minute;
    logic [15:0] event_tag;
    logic [4:0]  entry_index;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [15:0] out_tag;
    logic [5:0]  entry_count;
  } rsp_t;

endpackage

// ----- rtl/stet_store.sv -----
module stet_store import stet_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth,
  parameter int unsigned EntW  = KeyW + DefTagBits,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [EntW-1:0]  wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [EntW-1:0]  rdata_o
);

  logic [EntW-1:0] mem_q [DEPTH];
  logic [EntW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sorted_time_event_table.sv -----
// Insert writes an empty table directly, else shifts each later entry up a place and then
// writes the new one into the freed slot. Delete moves each later entry down a place; a read
// fetches its entry. Rejects and ignores stay in idle. The result strobe follows the last cycle.
// One entry moves per cycle through the single write and registered read port of the store.
// Reset clears the entry count and the sequencer; the store itself is not cleared.
// The receiver cannot stall: done_o is a single-cycle strobe.
module sorted_time_event_table import stet_pkg::*; #(
  parameter int unsigned DEPTH    = DefDepth,
  parameter int unsigned TAG_BITS = DefTagBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CmpW  = ((CntW > 5) ? CntW : 5) + 1;
  localparam int unsigned EntW  = KeyW + TAG_BITS;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic done_q, done_d;
  rsp_t rsp_q, rsp_d;

  logic mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0] mem_wdata, mem_rdata;

  logic accept, bad_time, is_full, is_empty, idx_beyond;
  logic del_more_idle, del_more_mv, shift_more;
  logic [CmpW-1:0] idx_w, cnt_w, pos_w, idx_p1, pos_p2;
  logic [CntW-1:0] cnt_m1, pos_m1, pos_m2;
  logic [TAG_BITS+15:0] tag_in_wide, tag_out_wide;
  logic [CntW+5:0] cnt_wide;
  logic [TAG_BITS-1:0] req_tag, rd_tag;
  logic [KeyW-1:0] req_key, rd_key;

  stet_store #(
    .DEPTH (DEPTH),
    .EntW  (EntW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start & ~busy;

  assign bad_time   = (req_i.event_hour > MaxHour) | (req_i.event_minute > MaxMinute);
  assign is_full    = (count_q == CntW'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign idx_w      = CmpW'(req_i.entry_index);
  assign cnt_w      = CmpW'(count_q);
  assign pos_w      = CmpW'(pos_q);
  assign idx_p1     = idx_w + CmpW'(1);
  assign pos_p2     = pos_w + CmpW'(2);
  assign idx_beyond = (idx_w >= cnt_w);
  assign cnt_m1     = count_q - CntW'(1);
  assign pos_m1     = pos_q - CntW'(1);
  assign pos_m2     = pos_q - CntW'(2);

  assign del_more_idle = (idx_p1 < cnt_w);
  assign del_more_mv   = (pos_p2 < cnt_w);

  assign tag_in_wide = {{TAG_BITS{1'b0}}, req_i.event_tag};
  assign req_tag     = tag_in_wide[TAG_BITS-1:0];
  assign req_key     = {req_i.event_hour, req_i.event_minute};

  assign rd_key       = mem_rdata[EntW-1 -: KeyW];
  assign rd_tag       = mem_rdata[TAG_BITS-1:0];
  assign tag_out_wide = {16'b0, rd_tag};

  // An entry moves up while its time is strictly later than the new one.
  assign shift_more = (rd_key > key_q);

  assign cnt_wide = {6'b0, count_d};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.mode)
            MODE_INSERT: begin
              if (!bad_time && !is_full && !is_empty) begin
                state_d = S_INS_CMP;
              end
            end
            MODE_DELETE: begin
              if (!is_empty && !idx_beyond && del_more_idle) begin
                state_d = S_DEL_MV;
              end
            end
            MODE_READ: begin
              if (!is_empty && !idx_beyond) begin
                state_d = S_RD_OUT;
              end
            end
            MODE_IGNORE: state_d = S_IDLE;
          endcase
        end
      end
      S_INS_CMP: begin
        if (shift_more) begin
          if (pos_q == CntW'(1)) begin
            state_d = S_INS_WR;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_INS_WR: state_d = S_IDLE;
      S_DEL_MV: begin
        if (!del_more_mv) begin
          state_d = S_IDLE;
        end
      end
      S_RD_OUT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_q[AddrW-1:0];
    mem_wdata = {key_q, tag_q};
    mem_re    = 1'b0;
    mem_raddr = pos_m1[AddrW-1:0];
    pos_d     = pos_q;
    count_d   = count_q;
    key_d     = key_q;
    tag_d     = tag_q;
    done_d    = 1'b0;
    rsp_d     = '0;
    rsp_d.status = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = req_key;
          tag_d = req_tag;
          pos_d = count_q;
          unique case (req_i.mode)
            MODE_INSERT: begin
              if (bad_time) begin
                done_d       = 1'b1;
                rsp_d.status = ST_BAD_TIME;
              end else if (is_full) begin
                done_d       = 1'b1;
                rsp_d.status = ST_FULL;
              end else if (is_empty) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {req_key, req_tag};
                count_d   = count_q + CntW'(1);
                done_d    = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_m1[AddrW-1:0];
              end
            end
            MODE_DELETE, MODE_READ: begin
              if (is_empty) begin
                done_d       = 1'b1;
                rsp_d.status = ST_EMPTY;
              end else if (idx_beyond) begin
                done_d       = 1'b1;
                rsp_d.status = ST_RANGE;
              end else if (req_i.mode == MODE_READ) begin
                mem_re    = 1'b1;
                mem_raddr = idx_w[AddrW-1:0];
              end else begin
                pos_d = idx_w[CntW-1:0];
                if (del_more_idle) begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_p1[AddrW-1:0];
                end else begin
                  count_d = cnt_m1;
                  done_d  = 1'b1;
                end
              end
            end
            MODE_IGNORE: done_d = 1'b1;
          endcase
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (shift_more) begin
          mem_wdata = mem_rdata;
          pos_d     = pos_m1;
          if (pos_q != CntW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = pos_m2[AddrW-1:0];
          end
        end else begin
          count_d = count_q + CntW'(1);
          done_d  = 1'b1;
        end
      end
      S_INS_WR: begin
        mem_we  = 1'b1;
        count_d = count_q + CntW'(1);
        done_d  = 1'b1;
      end
      S_DEL_MV: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        pos_d     = pos_q + CntW'(1);
        if (del_more_mv) begin
          mem_re    = 1'b1;
          mem_raddr = pos_p2[AddrW-1:0];
        end else begin
          count_d = cnt_m1;
          done_d  = 1'b1;
        end
      end
      S_RD_OUT: begin
        done_d           = 1'b1;
        rsp_d.out_hour   = rd_key[KeyW-1:6];
        rsp_d.out_minute = rd_key[5:0];
        rsp_d.out_tag    = tag_out_wide[15:0];
      end
      default: ;
    endcase

    rsp_d.entry_count = cnt_wide[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    key_q <= key_d;
    tag_q <= tag_d;
    if (done_d) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above table depth");

  a_accept_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted command neither in progress nor answered");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer still busy");

  a_reject_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> $stable(count_q))
    else $error("rejected command changed the entry count");

  a_reject_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.out_tag == '0 && rsp_o.out_hour == '0))
    else $error("rejected command returned entry data");

endmodule
